[rtl/gwsc_pkg.sv]
// Shared types, constants and the segment compare function of the grid word search counter.
`timescale 1ns / 1ps
package gwsc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WORD   = 4;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int LEN_W      = 3;
  localparam int SLOT_W     = $clog2(MAX_WORD);
  localparam int ROWS_W     = SLOT_W;
  localparam int LETTER_W   = 8;
  localparam int COUNT_W    = 32;
  localparam int ADD_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [LETTER_W-1:0]              letter_t;
  typedef logic [COL_W-1:0]                 col_t;
  typedef logic [WIDTH_W-1:0]               width_t;
  typedef logic [LEN_W-1:0]                 len_t;
  typedef logic [SLOT_W-1:0]                slot_t;
  typedef logic [ROWS_W-1:0]                rows_t;
  typedef logic [COUNT_W-1:0]               count_t;
  typedef logic [ADD_W-1:0]                 add_t;
  typedef logic [MAX_WORD*LETTER_W-1:0]     word_t;
  typedef logic [MAX_WORD-1:0][LETTER_W-1:0] seg_t;

  // Cell k of each segment lies k steps back from the newest letter.
  typedef struct packed {
    seg_t row_seg;
    seg_t col_seg;
    seg_t diag_seg;
    seg_t anti_seg;
  } window_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH    = 2'd0,
    REG_WORD_LENGTH  = 2'd1,
    REG_WORD_LETTERS = 2'd2
  } cfg_reg_t;

  localparam width_t ROW_WIDTH_RST    = width_t'(MAX_WIDTH);
  localparam len_t   WORD_LENGTH_RST  = len_t'(MAX_WORD);
  localparam word_t  WORD_LETTERS_RST = 32'h5341_4D58;
  localparam rows_t  ROWS_MAX         = rows_t'(MAX_WORD - 1);

  // Forward plus reversed matches of one segment against the word.
  function automatic logic [1:0] seg_matches(seg_t cells, len_t len, word_t word);
    logic  fwd;
    logic  rev;
    slot_t idx;
    fwd = 1'b1;
    rev = 1'b1;
    for (int k = 0; k < MAX_WORD; k++) begin
      idx = slot_t'(len - len_t'(1) - len_t'(k));
      if (len_t'(k) < len) begin
        if (cells[idx] != word[LETTER_W*k +: LETTER_W]) fwd = 1'b0;
        if (cells[k] != word[LETTER_W*k +: LETTER_W]) rev = 1'b0;
      end
    end
    return {1'b0, fwd} + {1'b0, rev};
  endfunction

endpackage

[rtl/gwsc_window.sv]
// Line stores of the previous rows and the letter window around the current cell.
`timescale 1ns / 1ps
module gwsc_window import gwsc_pkg::*; (
  input  logic    clk,
  input  logic    accept,
  input  letter_t letter,
  input  slot_t   wr_slot,
  input  col_t    wr_col,
  input  slot_t   rd_slot,
  input  col_t    rd_col,
  output window_t win
);

  letter_t rd_a_r [MAX_WORD];
  letter_t rd_b_r [MAX_WORD];

  letter_t                   hist1_r;
  logic [1:0][LETTER_W-1:0]  hist2_r;
  logic [2:0][LETTER_W-1:0]  hist3_r;
  logic [2:0][LETTER_W-1:0]  cur_r;

  for (genvar b = 0; b < MAX_WORD; b++) begin : g_bank
    letter_t line_mem [MAX_WIDTH];
    slot_t   back_d;
    col_t    addr_b;
    logic    wr_hit;

    assign back_d = rd_slot - slot_t'(b);
    assign addr_b = rd_col + col_t'(back_d);
    assign wr_hit = accept && (wr_slot == slot_t'(b));

    always_ff @(posedge clk) begin
      if (wr_hit) begin
        line_mem[wr_col] <= letter;
      end
      rd_a_r[b] <= (wr_hit && wr_col == rd_col) ? letter : line_mem[rd_col];
      rd_b_r[b] <= (wr_hit && wr_col == addr_b) ? letter : line_mem[addr_b];
    end
  end

  slot_t   bank1, bank2, bank3;
  letter_t up1, up2, up3;
  letter_t far1, far2, far3;

  always_comb begin
    bank1 = wr_slot - slot_t'(1);
    bank2 = wr_slot - slot_t'(2);
    bank3 = wr_slot - slot_t'(3);
    up1   = rd_a_r[bank1];
    up2   = rd_a_r[bank2];
    up3   = rd_a_r[bank3];
    far1  = rd_b_r[bank1];
    far2  = rd_b_r[bank2];
    far3  = rd_b_r[bank3];
    win.row_seg  = {cur_r[2], cur_r[1], cur_r[0], letter};
    win.col_seg  = {up3, up2, up1, letter};
    win.diag_seg = {hist3_r[2], hist2_r[1], hist1_r, letter};
    win.anti_seg = {far3, far2, far1, letter};
  end

  // Shift the window one column on every item.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r   <= {cur_r[1:0], letter};
      hist1_r <= up1;
      hist2_r <= {hist2_r[0], up2};
      hist3_r <= {hist3_r[1:0], up3};
    end
  end

endmodule

[rtl/gwsc_match.sv]
// Bounds masks and word compare of the four segments that end at the current cell.
`timescale 1ns / 1ps
module gwsc_match import gwsc_pkg::*; (
  input  window_t win,
  input  col_t    col,
  input  width_t  width,
  input  len_t    len,
  input  rows_t   rows_avail,
  input  word_t   word,
  output add_t    add
);

  slot_t      len_m1;
  logic       row_ok, vert_ok, anti_ok;
  logic [1:0] m_row, m_col, m_diag, m_anti;

  always_comb begin
    len_m1  = slot_t'(len - len_t'(1));
    row_ok  = col >= col_t'(len_m1);
    vert_ok = rows_avail >= rows_t'(len_m1);
    anti_ok = (width_t'(col) + width_t'(len_m1)) < width;
    m_row   = row_ok ? seg_matches(win.row_seg, len, word) : 2'd0;
    m_col   = vert_ok ? seg_matches(win.col_seg, len, word) : 2'd0;
    m_diag  = (row_ok && vert_ok) ? seg_matches(win.diag_seg, len, word) : 2'd0;
    m_anti  = (anti_ok && vert_ok) ? seg_matches(win.anti_seg, len, word) : 2'd0;
    add     = add_t'(m_row) + add_t'(m_col) + add_t'(m_diag) + add_t'(m_anti);
  end

endmodule

[rtl/gwsc_accum.sv]
// Per-item match register, saturating grid total and result output register.
`timescale 1ns / 1ps
module gwsc_accum import gwsc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  add_t   add,
  input  logic   last,
  output logic   in_ready,
  output logic   out_tvalid,
  input  logic   out_tready,
  output count_t out_tdata
);

  logic   s1_valid_r;
  logic   s1_last_r;
  add_t   s1_add_r;
  count_t total_r;
  logic   out_valid_r;
  count_t out_data_r;

  logic               ok, fire;
  logic [COUNT_W:0]   sum;
  count_t             total_nxt;

  always_comb begin
    ok        = !s1_last_r || !out_valid_r || out_tready;
    fire      = s1_valid_r && ok;
    in_ready  = !s1_valid_r || ok;
    sum       = {1'b0, total_r} + (COUNT_W + 1)'(s1_add_r);
    total_nxt = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_last_r   <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
        s1_last_r  <= last;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
        s1_last_r  <= 1'b0;
      end
      if (fire) begin
        total_r <= s1_last_r ? '0 : total_nxt;
      end
      if (fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_add_r <= add;
    end
    if (fire && s1_last_r) begin
      out_data_r <= total_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/grid_word_search_count.sv]
// Output: the total of a grid passes the per-item match register, then the result register,
// and leaves on out_*. Throughput: one letter per cycle; the line store reads for the next
// cell are issued while the current one is taken, so no letter waits on the memories.
// Input stalls only when a grid ends while the previous total still waits on out_tready.
// Reset: synchronous, active low; restores the registers and clears the row position and
// total. Line stores are not cleared: rows not yet seen in a grid are masked.
`timescale 1ns / 1ps
module grid_word_search_count import gwsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [LETTER_W-1:0]   in_tdata,   // [7:0] letter
  input  logic                  in_tlast,   // last_of_grid
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [COUNT_W-1:0]    out_tdata,  // [31:0] match_count
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  width_t row_width_r;
  len_t   word_length_r;
  word_t  word_letters_r;
  col_t   col_r;
  slot_t  slot_r;
  rows_t  rows_r;

  logic    accept;
  width_t  width_eff;
  len_t    len_eff;
  col_t    col_cur;
  logic    row_end;
  col_t    col_nxt;
  slot_t   slot_nxt;
  rows_t   rows_nxt;
  window_t win;
  add_t    add;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    width_eff = row_width_r;
    if (row_width_r == '0) begin
      width_eff = width_t'(1);
    end else if (row_width_r > width_t'(MAX_WIDTH)) begin
      width_eff = width_t'(MAX_WIDTH);
    end
    len_eff = word_length_r;
    if (word_length_r == '0) begin
      len_eff = len_t'(1);
    end else if (word_length_r > len_t'(MAX_WORD)) begin
      len_eff = len_t'(MAX_WORD);
    end
    col_cur = (width_t'(col_r) >= width_eff) ? col_t'(width_eff - width_t'(1)) : col_r;
    row_end = (width_t'(col_cur) + width_t'(1)) >= width_eff;
  end

  always_comb begin
    col_nxt  = col_r;
    slot_nxt = slot_r;
    rows_nxt = rows_r;
    if (accept) begin
      if (in_tlast) begin
        col_nxt  = '0;
        slot_nxt = '0;
        rows_nxt = '0;
      end else if (row_end) begin
        col_nxt  = '0;
        slot_nxt = slot_r + slot_t'(1);
        rows_nxt = (rows_r == ROWS_MAX) ? rows_r : rows_r + rows_t'(1);
      end else begin
        col_nxt = col_cur + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= ROW_WIDTH_RST;
      word_length_r  <= WORD_LENGTH_RST;
      word_letters_r <= WORD_LETTERS_RST;
      col_r          <= '0;
      slot_r         <= '0;
      rows_r         <= '0;
    end else begin
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
      rows_r <= rows_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ROW_WIDTH:    row_width_r    <= cfg_wdata[WIDTH_W-1:0];
          REG_WORD_LENGTH:  word_length_r  <= cfg_wdata[LEN_W-1:0];
          REG_WORD_LETTERS: word_letters_r <= cfg_wdata[MAX_WORD*LETTER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  gwsc_window u_window (
    .clk     (clk),
    .accept  (accept),
    .letter  (in_tdata),
    .wr_slot (slot_r),
    .wr_col  (col_cur),
    .rd_slot (slot_nxt),
    .rd_col  (col_nxt),
    .win     (win)
  );

  gwsc_match u_match (
    .win        (win),
    .col        (col_cur),
    .width      (width_eff),
    .len        (len_eff),
    .rows_avail (rows_r),
    .word       (word_letters_r),
    .add        (add)
  );

  gwsc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .add        (add),
    .last       (in_tlast),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
